/* src/spring_column_water_surface_macros.svh */
// assertion macros for the water surface checker
`ifndef SPRING_COLUMN_WATER_SURFACE_MACROS_SVH
`define SPRING_COLUMN_WATER_SURFACE_MACROS_SVH

// clocked assertion, quiet while reset is held
`define SCWS_CHECK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// clocked assertion that also holds during reset
`define SCWS_CHECK_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* src/scws_pkg.sv */
// shared types, codes and saturating arithmetic for the water surface
`timescale 1ns / 1ps
package scws_pkg;

    localparam logic [1:0] KIND_LOAD    = 2'd0;
    localparam logic [1:0] KIND_DISTURB = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;
    localparam logic [1:0] KIND_READ    = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_TICK = 2'd1;
    localparam logic [1:0] STAT_ERR  = 2'd2;

    localparam logic [2:0] REG_COLUMNS = 3'd0;
    localparam logic [2:0] REG_TENSION = 3'd1;
    localparam logic [2:0] REG_DAMPING = 3'd2;
    localparam logic [2:0] REG_SPREAD  = 3'd3;
    localparam logic [2:0] REG_PASSES  = 3'd4;

    // one water column
    typedef struct packed {
        logic [31:0] h;
        logic [31:0] v;
        logic [31:0] r;
    } t_col;

    // control handed to the column unit
    typedef struct packed {
        logic start;
        logic spring;
        logic first;
        logic last;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > 64'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (x < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

    // drop 16 fraction bits rounding down, then saturate
    function automatic logic signed [31:0] rescale(input logic signed [63:0] x);
        logic signed [63:0] s;
        s = x >>> 16;
        return sat32(s);
    endfunction

    function automatic logic signed [31:0] sadd(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] s;
        s = a;
        s = s + b;
        return sat32(s);
    endfunction

endpackage

/* src/spring_column_water_surface.sv */
// top level of the spring column water surface
//
// channel   dir  handshake                 payload
// s         in   i_s_tvalid / o_s_tready   tuser kind, tdata index, value, rest, dt
// m         out  o_m_tvalid / i_m_tready   tuser status, tdata height, velocity
// cfg       in   i_cfg_valid / o_cfg_ready index, data
//
// a tick walks the column ring ROUNDS_PER_TICK times, each round one spring
// sweep plus spread_passes sweeps, each sweep MAX_COLUMNS slots; an active
// column goes through the one shared column unit, an idle slot only shifts
// synchronous active-low reset clears every column; input waits while a tick runs
`timescale 1ns / 1ps
module spring_column_water_surface #(
    parameter int MAX_COLUMNS     = 64,
    parameter int ROUNDS_PER_TICK = 10
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // [5:0] column_index, [37:6] value, [69:38] rest_value, [85:70] step_dt
    input  logic [87:0] i_s_tdata,
    // [1:0] kind
    input  logic [1:0]  i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // [31:0] column_height, [63:32] column_velocity
    output logic [63:0] o_m_tdata,
    // [1:0] status
    output logic [1:0]  o_m_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data
);

    localparam int PW = $clog2(MAX_COLUMNS);
    localparam int NW = ($clog2(MAX_COLUMNS + 1) > 7) ? $clog2(MAX_COLUMNS + 1) : 7;
    localparam int RW = $clog2(ROUNDS_PER_TICK + 1);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_COL  = 4'b0010,
        S_CALC = 4'b0100,
        S_DONE = 4'b1000
    } t_state;

    t_state r_state;

    // configuration registers
    logic [6:0]  r_columns;
    logic [23:0] r_tension;
    logic [23:0] r_damping;
    logic [23:0] r_spread;
    logic [3:0]  r_passes;

    // tick sequencing
    logic [PW-1:0] r_pos;
    logic          r_spring;
    logic [3:0]    r_pass;
    logic [RW-1:0] r_round;
    logic [15:0]   r_dt;
    logic signed [31:0] r_hprev;

    // output register
    logic        r_ov;
    logic [1:0]  r_ostat;
    logic [31:0] r_oh;
    logic [31:0] r_ovel;

    // input fields
    logic [1:0]         w_kind;
    logic [5:0]         w_index;
    logic signed [31:0] w_value;
    logic signed [31:0] w_rest;
    logic [15:0]        w_dt;

    logic          w_in_acc;
    logic          w_slot_free;
    logic [NW-1:0] w_n;
    logic [NW-1:0] w_idx;
    logic [NW-1:0] w_pos;
    logic          w_active;
    logic          w_shift;
    logic          w_sweep_end;

    scws_pkg::t_col w_cols [MAX_COLUMNS];
    scws_pkg::t_col w_tail;
    scws_pkg::t_col w_unit_col;
    scws_pkg::t_job w_job;
    logic           w_unit_done;

    assign w_kind  = i_s_tuser;
    assign w_index = i_s_tdata[5:0];
    assign w_value = i_s_tdata[37:6];
    assign w_rest  = i_s_tdata[69:38];
    assign w_dt    = i_s_tdata[85:70];

    // active count clamps at the ring length
    assign w_n   = (NW'(r_columns) > NW'(MAX_COLUMNS)) ? NW'(MAX_COLUMNS) : NW'(r_columns);
    assign w_idx = NW'(w_index);
    assign w_pos = NW'(r_pos);

    assign w_slot_free = !r_ov || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE) && w_slot_free;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    // head column is processed only when it lies inside the active span
    assign w_active    = w_pos < w_n;
    assign w_shift     = ((r_state == S_COL) && !w_active) ||
                         ((r_state == S_CALC) && w_unit_done);
    assign w_sweep_end = r_pos == PW'(MAX_COLUMNS - 1);
    assign w_tail      = (r_state == S_CALC) ? w_unit_col : w_cols[0];

    assign w_job.start  = (r_state == S_COL) && w_active;
    assign w_job.spring = r_spring;
    assign w_job.first  = r_pos == '0;
    assign w_job.last   = w_pos == (w_n - NW'(1));

    // ring of cells, each hands its column toward the head on a shift
    for (genvar k = 0; k < MAX_COLUMNS; k++) begin : g_ring
        scws_pkg::t_col w_in;
        if (k == MAX_COLUMNS - 1) begin : g_last
            assign w_in = w_tail;
        end else begin : g_mid
            assign w_in = w_cols[k + 1];
        end
        scws_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_shift   (w_shift),
            .i_col     (w_in),
            .i_load    (w_in_acc && (w_kind == scws_pkg::KIND_LOAD) && (w_idx == NW'(k))),
            .i_disturb (w_in_acc && (w_kind == scws_pkg::KIND_DISTURB) &&
                        (w_idx == NW'(k)) && (w_idx < w_n)),
            .i_value   (w_value),
            .i_rest    (w_rest),
            .o_col     (w_cols[k])
        );
    end

    scws_unit u_unit (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_job     (w_job),
        .i_col     (w_cols[0]),
        .i_hl      (r_hprev),
        .i_hr      (w_cols[1].h),
        .i_dt      (r_dt),
        .i_tension (r_tension),
        .i_damping (r_damping),
        .i_spread  (r_spread),
        .o_done    (w_unit_done),
        .o_col     (w_unit_col)
    );

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 7'd64;
            r_tension <= 24'd1638;
            r_damping <= 24'd1638;
            r_spread  <= 24'd16384;
            r_passes  <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                scws_pkg::REG_COLUMNS: r_columns <= i_cfg_data[6:0];
                scws_pkg::REG_TENSION: r_tension <= i_cfg_data;
                scws_pkg::REG_DAMPING: r_damping <= i_cfg_data;
                scws_pkg::REG_SPREAD:  r_spread  <= i_cfg_data;
                scws_pkg::REG_PASSES:  r_passes  <= i_cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    // tick sequencer: slot, sweep kind, pass and round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_pos    <= '0;
            r_spring <= 1'b1;
            r_pass   <= '0;
            r_round  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc && (w_kind == scws_pkg::KIND_TICK)) begin
                        r_state  <= S_COL;
                        r_pos    <= '0;
                        r_spring <= 1'b1;
                        r_pass   <= '0;
                        r_round  <= '0;
                    end
                end
                S_COL, S_CALC: begin
                    if (w_job.start) begin
                        r_state <= S_CALC;
                    end else if (w_shift) begin
                        r_state <= S_COL;
                        if (!w_sweep_end) begin
                            r_pos <= r_pos + PW'(1);
                        end else begin
                            r_pos <= '0;
                            if (r_spring && (r_passes != 4'd0)) begin
                                r_spring <= 1'b0;
                                r_pass   <= '0;
                            end else if (!r_spring && (r_pass != r_passes - 4'd1)) begin
                                r_pass <= r_pass + 4'd1;
                            end else if (r_round == RW'(ROUNDS_PER_TICK - 1)) begin
                                r_state <= S_DONE;
                            end else begin
                                r_round  <= r_round + RW'(1);
                                r_spring <= 1'b1;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (w_slot_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // tick payload: time step and the head column's height before its update
    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_kind == scws_pkg::KIND_TICK)) begin
            r_dt <= w_dt;
        end
        if (w_shift) begin
            r_hprev <= w_cols[0].h;
        end
    end

    // output register, refilled in the cycle the old request leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((w_in_acc && (w_kind == scws_pkg::KIND_READ)) ||
                     ((r_state == S_DONE) && w_slot_free)) begin
            r_ov <= 1'b1;
        end else if (i_m_tready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && (w_kind == scws_pkg::KIND_READ)) begin
            if (w_idx < w_n) begin
                r_ostat <= scws_pkg::STAT_OK;
                r_oh    <= w_cols[w_idx[PW-1:0]].h;
                r_ovel  <= w_cols[w_idx[PW-1:0]].v;
            end else begin
                r_ostat <= scws_pkg::STAT_ERR;
                r_oh    <= '0;
                r_ovel  <= '0;
            end
        end else if ((r_state == S_DONE) && w_slot_free) begin
            r_ostat <= scws_pkg::STAT_TICK;
            r_oh    <= '0;
            r_ovel  <= '0;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tuser  = r_ostat;
    assign o_m_tdata  = {r_ovel, r_oh};

endmodule

/* src/scws_cell.sv */
// one storage cell of the column ring: height, velocity, rest height
`timescale 1ns / 1ps
module scws_cell (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_shift,
    input  scws_pkg::t_col     i_col,
    input  logic               i_load,
    input  logic               i_disturb,
    input  logic signed [31:0] i_value,
    input  logic signed [31:0] i_rest,
    output scws_pkg::t_col     o_col
);

    logic signed [31:0] r_h;
    logic signed [31:0] r_v;
    logic signed [31:0] r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h <= '0;
            r_v <= '0;
            r_r <= '0;
        end else if (i_shift) begin
            r_h <= i_col.h;
            r_v <= i_col.v;
            r_r <= i_col.r;
        end else if (i_load) begin
            r_h <= i_value;
            r_v <= '0;
            r_r <= i_rest;
        end else if (i_disturb) begin
            r_v <= scws_pkg::sadd(r_v, i_value);
        end
    end

    assign o_col = '{h: r_h, v: r_v, r: r_r};

endmodule

/* src/scws_unit.sv */
// column update unit: spring step or one spreading pass for the head column
`timescale 1ns / 1ps
module scws_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  scws_pkg::t_job     i_job,
    input  scws_pkg::t_col     i_col,
    input  logic signed [31:0] i_hl,
    input  logic signed [31:0] i_hr,
    input  logic [15:0]        i_dt,
    input  logic [23:0]        i_tension,
    input  logic [23:0]        i_damping,
    input  logic [23:0]        i_spread,
    output logic               o_done,
    output scws_pkg::t_col     o_col
);

    logic               r_busy;
    logic [2:0]         r_step;
    logic               r_done;
    logic               r_spring;
    logic               r_first;
    logic               r_last;
    logic signed [31:0] r_h;
    logic signed [31:0] r_v;
    logic signed [31:0] r_r;
    logic signed [31:0] r_hl;
    logic signed [31:0] r_hr;
    logic signed [63:0] r_m0;
    logic signed [63:0] r_m1;
    logic signed [31:0] r_s0;
    logic signed [31:0] r_s1;
    logic signed [63:0] w_diff;
    logic signed [31:0] w_d;
    logic signed [31:0] w_a;
    logic signed [31:0] w_b;
    logic signed [16:0] w_dt;
    logic [2:0]         w_last_step;

    assign w_dt        = $signed({1'b0, i_dt});
    assign w_last_step = r_spring ? 3'd6 : 3'd4;

    always_comb begin
        w_diff = r_h;
        w_diff = w_diff - r_r;
        w_d    = scws_pkg::sat32(w_diff);
        w_a    = r_first ? 32'sd0 : scws_pkg::rescale(r_m0);
        w_b    = r_last  ? 32'sd0 : scws_pkg::rescale(r_m1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_step <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_step == w_last_step);
            if (i_job.start) begin
                r_busy <= 1'b1;
                r_step <= 3'd1;
            end else if (r_busy) begin
                if (r_step == w_last_step) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_job.start) begin
            r_spring <= i_job.spring;
            r_first  <= i_job.first;
            r_last   <= i_job.last;
            r_h      <= i_col.h;
            r_v      <= i_col.v;
            r_r      <= i_col.r;
            r_hl     <= i_hl;
            r_hr     <= i_hr;
        end else if (r_busy) begin
            case (r_step)
                3'd1: begin
                    if (r_spring) begin
                        r_m0 <= $signed({1'b0, i_tension}) * w_d;
                        r_m1 <= $signed({1'b0, i_damping}) * r_v;
                    end else begin
                        r_m0 <= $signed({1'b0, i_spread}) * (r_hl - r_h);
                        r_m1 <= $signed({1'b0, i_spread}) * (r_hr - r_h);
                    end
                end
                3'd2: begin
                    if (r_spring) begin
                        r_s0 <= scws_pkg::rescale(-r_m0 - r_m1);
                    end else begin
                        r_s0 <= scws_pkg::rescale(r_m0);
                        r_s1 <= scws_pkg::rescale(r_m1);
                    end
                end
                3'd3: begin
                    r_m0 <= r_s0 * w_dt;
                    r_m1 <= r_s1 * w_dt;
                end
                3'd4: begin
                    if (r_spring) begin
                        r_v <= scws_pkg::sadd(r_v, scws_pkg::rescale(r_m0));
                    end else begin
                        // left neighbour term lands first, then the right one
                        r_v <= scws_pkg::sadd(scws_pkg::sadd(r_v, w_a), w_b);
                        r_h <= scws_pkg::sadd(scws_pkg::sadd(r_h, w_a), w_b);
                    end
                end
                3'd5: begin
                    r_m0 <= r_v * w_dt;
                end
                3'd6: begin
                    // position gain of ten as shift and add
                    r_h <= scws_pkg::sadd(r_h, scws_pkg::rescale((r_m0 <<< 3) + (r_m0 <<< 1)));
                end
                default: begin
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_col  = '{h: r_h, v: r_v, r: r_r};

endmodule

/* src/scws_checker.sv */
// port-level checker for the water surface, bound to the top level
`timescale 1ns / 1ps
`include "spring_column_water_surface_macros.svh"
module scws_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [87:0] i_s_tdata,
    input logic [1:0]  i_s_tuser,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [63:0] o_m_tdata,
    input logic [1:0]  o_m_tuser,
    input logic        i_cfg_valid,
    input logic        o_cfg_ready,
    input logic [2:0]  i_cfg_index,
    input logic [23:0] i_cfg_data
);

    `SCWS_CHECK(a_out_holds, (o_m_tvalid && !i_m_tready) |=> o_m_tvalid, "result dropped")
    `SCWS_CHECK(a_tick_zero, (o_m_tvalid && (o_m_tuser == scws_pkg::STAT_TICK)) |-> (o_m_tdata == 64'd0), "tick data not zero")
    `SCWS_CHECK(a_err_zero, (o_m_tvalid && (o_m_tuser == scws_pkg::STAT_ERR)) |-> (o_m_tdata == 64'd0), "range error data not zero")
    `SCWS_CHECK(a_tick_busy, (i_s_tvalid && o_s_tready && (i_s_tuser == scws_pkg::KIND_TICK)) |=> !o_s_tready, "input taken during tick")

endmodule

bind spring_column_water_surface scws_checker u_scws_checker (.*);

/* test/spring_column_water_surface_checker.sv */
// predictor and result checker for the spring column water surface
`timescale 1ns / 1ps
module spring_column_water_surface_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [87:0] i_s_tdata,
    input  logic [1:0]  i_s_tuser,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    output int          o_errors,
    output int          o_pending,
    output int          o_reads,
    output int          o_ticks
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] height;
        logic [31:0] velocity;
    } t_reply;

    logic signed [31:0] col_h [64];
    logic signed [31:0] col_v [64];
    logic signed [31:0] col_r [64];
    logic signed [31:0] dl    [64];
    logic signed [31:0] dr    [64];
    logic [6:0]  cols_cfg;
    logic [23:0] tension_cfg, damping_cfg, spread_cfg;
    logic [3:0]  passes_cfg;
    t_reply      reply_q[$];

    function automatic logic signed [31:0] clip32(input longint x);
        logic signed [31:0] res;
        if (x > 64'sd2147483647) res = 32'sh7fffffff;
        else if (x < -64'sd2147483648) res = 32'sh80000000;
        else res = x[31:0];
        return res;
    endfunction

    // floor division by 2^16, then clip
    function automatic logic signed [31:0] drop_frac(input longint p);
        return clip32(p >>> 16);
    endfunction

    function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        longint s;
        s = longint'(a) + longint'(b);
        return clip32(s);
    endfunction

    task automatic simulate_round(input int n, input longint dt);
        longint t, dmp, spr, d, a;
        t   = longint'({40'd0, tension_cfg});
        dmp = longint'({40'd0, damping_cfg});
        spr = longint'({40'd0, spread_cfg});
        for (int c = 0; c < n; c++) begin
            d = clip32(longint'(col_h[c]) - longint'(col_r[c]));
            a = drop_frac(-(t * d) - (dmp * longint'(col_v[c])));
            col_v[c] = add_sat(col_v[c], drop_frac(a * dt));
            col_h[c] = add_sat(col_h[c], drop_frac(longint'(col_v[c]) * dt * 10));
        end
        for (int p = 0; p < int'(passes_cfg); p++) begin
            // deltas come from the heights at the start of the pass
            for (int c = 0; c < n; c++) begin
                if (c > 0) begin
                    dl[c] = drop_frac(spr * (longint'(col_h[c]) - longint'(col_h[c-1])));
                    col_v[c-1] = add_sat(col_v[c-1], drop_frac(longint'(dl[c]) * dt));
                end
                if (c < n - 1) begin
                    dr[c] = drop_frac(spr * (longint'(col_h[c]) - longint'(col_h[c+1])));
                    col_v[c+1] = add_sat(col_v[c+1], drop_frac(longint'(dr[c]) * dt));
                end
            end
            for (int c = 0; c < n; c++) begin
                if (c > 0)
                    col_h[c-1] = add_sat(col_h[c-1], drop_frac(longint'(dl[c]) * dt));
                if (c < n - 1)
                    col_h[c+1] = add_sat(col_h[c+1], drop_frac(longint'(dr[c]) * dt));
            end
        end
    endtask

    task automatic apply_request(input logic [1:0] kind, input logic [87:0] data);
        logic [5:0]         idx;
        logic signed [31:0] val, rest;
        longint             dt;
        int                 n;
        t_reply             rep;
        idx  = data[5:0];
        val  = data[37:6];
        rest = data[69:38];
        dt   = longint'({48'd0, data[85:70]});
        n    = (cols_cfg > 7'd64) ? 64 : int'(cols_cfg);
        rep  = '0;
        case (kind)
            scws_pkg::KIND_LOAD: begin
                col_h[idx] = val;
                col_r[idx] = rest;
                col_v[idx] = '0;
            end
            scws_pkg::KIND_DISTURB: begin
                if (int'(idx) < n) col_v[idx] = add_sat(col_v[idx], val);
            end
            scws_pkg::KIND_TICK: begin
                for (int r = 0; r < 10; r++) simulate_round(n, dt);
                rep.status = scws_pkg::STAT_TICK;
                reply_q.push_back(rep);
                o_ticks++;
            end
            default: begin
                if (int'(idx) < n) begin
                    rep.status   = scws_pkg::STAT_OK;
                    rep.height   = col_h[idx];
                    rep.velocity = col_v[idx];
                end else begin
                    rep.status = scws_pkg::STAT_ERR;
                end
                reply_q.push_back(rep);
                o_reads++;
            end
        endcase
    endtask

    initial begin
        o_errors = 0;
        o_reads  = 0;
        o_ticks  = 0;
    end

    assign o_pending = reply_q.size();

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int c = 0; c < 64; c++) begin
                col_h[c] = '0;
                col_v[c] = '0;
                col_r[c] = '0;
            end
            cols_cfg    = 7'd64;
            tension_cfg = 24'd1638;
            damping_cfg = 24'd1638;
            spread_cfg  = 24'd16384;
            passes_cfg  = 4'd8;
        end else begin
            // results first: a request never answers in its own cycle
            if (i_m_tvalid && i_m_tready) begin
                if (reply_q.size() == 0) begin
                    $display("%0t: unexpected result status %0d data %h",
                             $time, i_m_tuser, i_m_tdata);
                    o_errors++;
                end else begin
                    want = reply_q.pop_front();
                    if (want.status !== i_m_tuser) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, i_m_tuser);
                        o_errors++;
                    end
                    if (want.height !== i_m_tdata[31:0]) begin
                        $display("%0t: height expected %h actual %h",
                                 $time, want.height, i_m_tdata[31:0]);
                        o_errors++;
                    end
                    if (want.velocity !== i_m_tdata[63:32]) begin
                        $display("%0t: velocity expected %h actual %h",
                                 $time, want.velocity, i_m_tdata[63:32]);
                        o_errors++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) apply_request(i_s_tuser, i_s_tdata);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    scws_pkg::REG_COLUMNS: cols_cfg    = i_cfg_data[6:0];
                    scws_pkg::REG_TENSION: tension_cfg = i_cfg_data;
                    scws_pkg::REG_DAMPING: damping_cfg = i_cfg_data;
                    scws_pkg::REG_SPREAD:  spread_cfg  = i_cfg_data;
                    scws_pkg::REG_PASSES:  passes_cfg  = i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

/* test/tb.sv */
// stimulus, idling and verdict for the spring column water surface
`timescale 1ns / 1ps
module tb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [87:0] i_s_tdata = '0;
    logic [1:0]  i_s_tuser = '0;
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [63:0] o_m_tdata;
    logic [1:0]  o_m_tuser;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [23:0] i_cfg_data = '0;

    int errors, pending, reads_seen, ticks_seen;

    // flags of the last edge, read at the falling edge by the drivers
    logic s_fire = 1'b0, cfg_fire = 1'b0;

    // receiver controls
    bit quiet = 1'b0;      // no idling in the final part
    int hold_off = 0;      // long receiver stall, counted down by the receiver
    int active_cols = 64;  // mirror of the column count for stimulus shaping

    always #2 i_clk = ~i_clk;

    spring_column_water_surface u_top (.*);

    spring_column_water_surface_checker u_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(i_s_tvalid), .i_s_tready(o_s_tready),
        .i_s_tdata(i_s_tdata), .i_s_tuser(i_s_tuser),
        .i_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready),
        .i_m_tdata(o_m_tdata), .i_m_tuser(o_m_tuser),
        .i_cfg_valid(i_cfg_valid), .i_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending),
        .o_reads(reads_seen), .o_ticks(ticks_seen)
    );

    always @(posedge i_clk) begin
        s_fire   <= i_s_tvalid && o_s_tready;
        cfg_fire <= i_cfg_valid && o_cfg_ready;
    end

    // receiver: long hold-off when asked, else random stall bursts
    initial begin
        int burst;
        forever begin
            @(negedge i_clk);
            if (hold_off > 0) begin
                i_m_tready <= 1'b0;
                hold_off--;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 12);
                i_m_tready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    // fixed run limit
    initial begin
        #20000000;
        $display("spring_column_water_surface test failed");
        $finish;
    end

    // one request on the stream input; valid stays high across back-to-back requests unless a random gap is taken
    task automatic send(input logic [1:0] kind, input logic [5:0] idx,
                        input logic [31:0] val, input logic [31:0] rest,
                        input logic [15:0] dt);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 12);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= {2'b00, dt, rest, val, idx};
        do @(negedge i_clk); while (!s_fire);
    endtask

    task automatic drop_valid();
        i_s_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    // wait for every result, plus slack for a load or disturb still in flight
    task automatic drain();
        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    // valid stays high across back-to-back writes; set_regs drops it at the end
    task automatic write_reg(input logic [2:0] index, input logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        do @(negedge i_clk); while (!cfg_fire);
        if (index == scws_pkg::REG_COLUMNS)
            active_cols = (data[6:0] > 64) ? 64 : int'(data[6:0]);
    endtask

    task automatic set_regs(input logic [23:0] cols, input logic [23:0] tens,
                            input logic [23:0] damp, input logic [23:0] spr,
                            input logic [23:0] passes);
        drain();
        write_reg(scws_pkg::REG_COLUMNS, cols);
        write_reg(scws_pkg::REG_TENSION, tens);
        write_reg(scws_pkg::REG_DAMPING, damp);
        write_reg(scws_pkg::REG_SPREAD, spr);
        write_reg(scws_pkg::REG_PASSES, passes);
        // unmapped indexes must be ignored
        write_reg(3'(int'(scws_pkg::REG_PASSES) + $urandom_range(1, 3)), 24'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 5))
            0: v = 32'h7fffffff;
            1: v = 32'h80000000;
            2: v = $urandom;
            default: v = 32'($signed($urandom_range(0, 32'h3ffff)) - 32'sh20000);
        endcase
        return v;
    endfunction

    // a phase of random traffic: loads first for well-formed columns, then a mix
    task automatic random_phase(input int count, input int max_ticks);
        int          ticks, k;
        logic [5:0]  idx;
        ticks = 0;
        for (int c = 0; c < active_cols && c < 64; c++)
            if ($urandom_range(0, 1) != 0)
                send(scws_pkg::KIND_LOAD, 6'(c), pick_value(), pick_value(),
                     16'($urandom));
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 99);
            if ($urandom_range(0, 9) == 0 || active_cols == 0) idx = 6'($urandom);
            else idx = 6'($urandom_range(0, active_cols - 1));
            if (k < 25)
                send(scws_pkg::KIND_LOAD, idx, pick_value(), pick_value(), 16'($urandom));
            else if (k < 50)
                send(scws_pkg::KIND_DISTURB, idx, pick_value(), $urandom, 16'($urandom));
            else if (k < 94 || ticks >= max_ticks)
                send(scws_pkg::KIND_READ, idx, $urandom, $urandom, 16'($urandom));
            else begin
                send(scws_pkg::KIND_TICK, idx, $urandom, $urandom,
                     ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom));
                ticks++;
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset contents, extremes, out of range cases
        send(scws_pkg::KIND_READ, 6'd0, '0, '0, '0);
        send(scws_pkg::KIND_READ, 6'd63, '0, '0, '0);
        set_regs(24'd8, 24'd1638, 24'd1638, 24'd16384, 24'd2);
        send(scws_pkg::KIND_LOAD, 6'd0, 32'h7fffffff, 32'h80000000, 16'h0000);
        send(scws_pkg::KIND_LOAD, 6'd1, 32'h80000000, 32'h7fffffff, 16'hffff);
        send(scws_pkg::KIND_LOAD, 6'd63, 32'h00010000, 32'h0, 16'h0);   // beyond active count
        send(scws_pkg::KIND_DISTURB, 6'd0, 32'h7fffffff, '0, '0);       // full-scale positive push
        send(scws_pkg::KIND_DISTURB, 6'd1, 32'h80000000, '0, '0);
        send(scws_pkg::KIND_DISTURB, 6'd40, 32'h12345678, '0, '0);      // ignored, out of range
        send(scws_pkg::KIND_READ, 6'd0, '0, '0, '0);
        send(scws_pkg::KIND_READ, 6'd1, '0, '0, '0);
        send(scws_pkg::KIND_READ, 6'd63, '0, '0, '0);                   // out of range
        send(scws_pkg::KIND_TICK, 6'd0, '0, '0, 16'h0000);
        send(scws_pkg::KIND_READ, 6'd0, '0, '0, '0);
        send(scws_pkg::KIND_TICK, 6'd63, 32'hffffffff, 32'hffffffff, 16'hffff);
        send(scws_pkg::KIND_READ, 6'd0, '0, '0, '0);
        send(scws_pkg::KIND_READ, 6'd1, '0, '0, '0);
        send(scws_pkg::KIND_READ, 6'd2, '0, '0, '0);

        // zero active columns: ticks change nothing, every read is out of range
        set_regs(24'hffff80, 24'hffffff, 24'd0, 24'hffffff, 24'd15);
        send(scws_pkg::KIND_TICK, 6'd0, '0, '0, 16'hffff);
        send(scws_pkg::KIND_DISTURB, 6'd0, 32'h7fffffff, '0, '0);
        send(scws_pkg::KIND_READ, 6'd0, '0, '0, '0);
        send(scws_pkg::KIND_LOAD, 6'd5, 32'h00020000, 32'h0, '0);

        set_regs(24'd4, 24'd1638, 24'd1638, 24'd16384, 24'd2);
        random_phase(45, 6);
        // sender pause until every result is back, mid phase
        drain();
        random_phase(15, 2);

        // long receiver stall while reads pile up at the input
        hold_off = 400;
        for (int i = 0; i < 20; i++)
            send(scws_pkg::KIND_READ, 6'($urandom_range(0, 5)), '0, '0, '0);

        set_regs(24'd1, 24'd0, 24'd0, 24'd0, 24'd0);
        random_phase(30, 3);

        set_regs(24'd16, 24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom));
        random_phase(40, 3);

        // widest setting, large sizes only briefly
        set_regs(24'hffffff, 24'hffffff, 24'hffffff, 24'hffffff, 24'd15);
        random_phase(25, 1);

        set_regs(24'd2, 24'd65536, 24'd6554, 24'd32768, 24'd1);
        random_phase(40, 4);

        // last part without idling on either side
        set_regs(24'd12, 24'd1638, 24'd1638, 24'd16384, 24'd8);
        quiet = 1'b1;
        random_phase(40, 2);

        drop_valid();
        while (pending != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);

        $display("covered %0d reads and %0d ticks over column counts 0 to 64,",
                 reads_seen, ticks_seen);
        $display("with zero and full-scale coefficients and saturating values");
        if (errors == 0) begin
            $display("spring_column_water_surface test passed");
        end else begin
            $display("spring_column_water_surface test failed");
        end
        $finish;
    end

endmodule
